// ===== hw/rtl/tlmd_pkg.sv =====
// ----------------------------------------------------------------------------
// tlmd_pkg
// Shared types and codes for the typed length-prefixed message deframer.
// ----------------------------------------------------------------------------
package tlmd_pkg;

	localparam int unsigned HDR_BYTES = 4;
	localparam int unsigned OQ_DEPTH  = 3;

	typedef enum logic [1:0] {
		OK_HDR   = 2'd0,
		OK_DATA  = 2'd1,
		OK_ERR   = 2'd2,
		OK_REG   = 2'd3
	} out_kind_t;

	// header status
	localparam logic [1:0] HS_OK       = 2'd0;
	localparam logic [1:0] HS_BAD_TYPE = 2'd1;
	localparam logic [1:0] HS_LIMITS   = 2'd2;
	localparam logic [1:0] HS_SHORT    = 2'd3;

	// registration status
	localparam logic [1:0] RS_OK       = 2'd0;
	localparam logic [1:0] RS_BAD_TYPE = 2'd1;
	localparam logic [1:0] RS_DUP      = 2'd2;
	localparam logic [1:0] RS_MIN_MAX  = 2'd3;

	localparam logic IK_STREAM = 1'b0;
	localparam logic IK_REG    = 1'b1;

	typedef struct packed {
		out_kind_t   kind;
		logic [7:0]  payload_byte;
		logic [15:0] msg_type;
		logic [15:0] msg_size;
		logic [1:0]  status;
		logic        last;
	} res_t;

	typedef struct packed {
		logic [15:0] min_size;
		logic [15:0] max_size;
	} limits_t;

endpackage

// ===== hw/rtl/tlmd_limit_ram.sv =====
// ----------------------------------------------------------------------------
// tlmd_limit_ram
// Per-type size limit table: one synchronous read port, one write port,
// zero sweep after reset.
// ----------------------------------------------------------------------------
module tlmd_limit_ram #(
	parameter int unsigned NUM_TYPES = 256,
	parameter int unsigned IW        = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 rd_en,
	input  logic [IW-1:0]        rd_addr,
	output tlmd_pkg::limits_t    rd_data,
	input  logic                 wr_en,
	input  logic [IW-1:0]        wr_addr,
	input  tlmd_pkg::limits_t    wr_data,
	output logic                 clr_busy
);
	import tlmd_pkg::*;

	limits_t       mem [NUM_TYPES];
	logic [IW-1:0] clr_cnt_q;
	logic          clr_busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q  <= '0;
			clr_busy_q <= 1'b1;
		end else if (clr_busy_q) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
			if (clr_cnt_q == IW'(NUM_TYPES - 1)) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (clr_busy_q) begin
			mem[clr_cnt_q] <= '0;
		end else if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

	assign clr_busy = clr_busy_q;

endmodule

// ===== hw/rtl/tlmd_out_fifo.sv =====
// ----------------------------------------------------------------------------
// tlmd_out_fifo
// Small result queue decoupling the pipeline from the output stall.
// ----------------------------------------------------------------------------
module tlmd_out_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  tlmd_pkg::res_t push_data,
	output logic [1:0]     count,
	output logic           out_valid,
	input  logic           out_stall,
	output tlmd_pkg::res_t out_data
);
	import tlmd_pkg::*;

	res_t       slot_q [OQ_DEPTH];
	logic [1:0] wr_ptr_q;
	logic [1:0] rd_ptr_q;
	logic [1:0] cnt_q;
	logic       pop;

	assign pop = (cnt_q != 2'd0) && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == 2'(OQ_DEPTH - 1)) ? 2'd0 : wr_ptr_q + 2'd1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == 2'(OQ_DEPTH - 1)) ? 2'd0 : rd_ptr_q + 2'd1;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	assign count     = cnt_q;
	assign out_valid = (cnt_q != 2'd0);
	assign out_data  = slot_q[rd_ptr_q];

endmodule

// ===== hw/rtl/typed_length_message_deframer.sv =====
// ----------------------------------------------------------------------------
// typed_length_message_deframer
// Splits a byte stream into typed, length-prefixed messages and checks each
// header against a per-type size limit table filled by registration items.
//
//   channel | signals                                   | dir
//   --------+-------------------------------------------+----
//   in      | in_valid, in_stall, kind, data_byte,      | in
//           | reg_type, reg_min, reg_max                |
//   out     | out_valid, out_stall, out_kind,           | out
//           | payload_byte, msg_type, msg_size, status, |
//           | last_of_message                           |
//
// One item per cycle while in_stall is low. Limit table read at accept,
// checked and written back in s1, result queued; out_valid rises once the
// queue holds it. A lookup right after a write to the same entry is
// forwarded from that write. A sweep after reset zeroes the table, in_stall
// high; later it rises only when the 3-entry result queue plus s1 is full.
// ----------------------------------------------------------------------------
module typed_length_message_deframer #(
	parameter int unsigned NUM_TYPES = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        kind,
	input  logic [7:0]  data_byte,
	input  logic [15:0] reg_type,
	input  logic [15:0] reg_min,
	input  logic [15:0] reg_max,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  out_kind,
	output logic [7:0]  payload_byte,
	output logic [15:0] msg_type,
	output logic [15:0] msg_size,
	output logic [1:0]  status,
	output logic        last_of_message
);
	import tlmd_pkg::*;

	localparam int unsigned IW = $clog2(NUM_TYPES);

	logic          accept;
	logic          clr_busy;
	logic [1:0]    oq_cnt;
	logic [15:0]   rd_type;
	limits_t       rd_data;
	limits_t       entry;

	// s1 pipeline
	logic          valid_s1;
	logic          kind_s1;
	logic [7:0]    byte_s1;
	logic [15:0]   type_s1;
	logic [15:0]   min_s1;
	logic [15:0]   max_s1;

	// stream state
	logic          prev_byte_en;
	logic [7:0]    prev_byte_q;
	logic [1:0]    hdr_cnt_q;
	logic [23:0]   hdr_shift_q;
	logic [15:0]   pay_left_q;
	logic [15:0]   cur_type_q;
	logic [15:0]   cur_size_q;
	logic          err_q;

	logic [1:0]    hdr_cnt_d;
	logic [23:0]   hdr_shift_d;
	logic [15:0]   pay_left_d;
	logic [15:0]   cur_type_d;
	logic [15:0]   cur_size_d;
	logic          err_d;

	// write forwarding
	logic          wr_en;
	limits_t       wr_data;
	logic          wr_vld_q;
	logic [IW-1:0] wr_idx_q;
	limits_t       wr_data_q;

	logic          push;
	res_t          res;
	res_t          oq_data;

	logic [15:0]   h_size;
	logic [15:0]   h_type;
	logic          t_bad;
	logic          in_use;

	assign in_stall     = clr_busy || (({1'b0, oq_cnt} + {2'b0, valid_s1}) >= 3'(OQ_DEPTH));
	assign accept       = in_valid && !in_stall;
	assign prev_byte_en = accept && (kind == IK_STREAM);
	assign rd_type      = (kind == IK_REG) ? reg_type : {data_byte, prev_byte_q};

	tlmd_limit_ram #(
		.NUM_TYPES (NUM_TYPES),
		.IW        (IW)
	) u_ram (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (accept),
		.rd_addr  (rd_type[IW-1:0]),
		.rd_data  (rd_data),
		.wr_en    (wr_en),
		.wr_addr  (type_s1[IW-1:0]),
		.wr_data  (wr_data),
		.clr_busy (clr_busy)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1 <= kind;
			byte_s1 <= data_byte;
			type_s1 <= rd_type;
			min_s1  <= reg_min;
			max_s1  <= reg_max;
		end
		if (prev_byte_en) begin
			prev_byte_q <= data_byte;
		end
		if (wr_en) begin
			wr_idx_q  <= type_s1[IW-1:0];
			wr_data_q <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_vld_q <= 1'b0;
		end else begin
			wr_vld_q <= wr_en;
		end
	end

	assign entry  = (wr_vld_q && (wr_idx_q == type_s1[IW-1:0])) ? wr_data_q : rd_data;
	assign h_size = hdr_shift_q[15:0];
	assign h_type = {byte_s1, hdr_shift_q[23:16]};
	assign t_bad  = (type_s1 == 16'd0) || ({1'b0, type_s1} >= 17'(NUM_TYPES));
	assign in_use = (entry.min_size != 16'd0) || (entry.max_size != 16'd0);

	always_comb begin
		hdr_cnt_d   = hdr_cnt_q;
		hdr_shift_d = hdr_shift_q;
		pay_left_d  = pay_left_q;
		cur_type_d  = cur_type_q;
		cur_size_d  = cur_size_q;
		err_d       = err_q;
		wr_en       = 1'b0;
		wr_data     = '{min_size: min_s1, max_size: max_s1};
		push        = 1'b0;
		res         = '{kind: OK_REG, payload_byte: 8'd0, msg_type: type_s1,
		                msg_size: 16'd0, status: RS_OK, last: 1'b0};
		if (valid_s1) begin
			unique case (kind_s1)
				IK_REG: begin
					push = 1'b1;
					priority if (t_bad) begin
						res.status = RS_BAD_TYPE;
					end else if (in_use) begin
						res.status = RS_DUP;
					end else if (min_s1 > max_s1) begin
						res.status = RS_MIN_MAX;
					end else begin
						wr_en = 1'b1;
					end
				end
				IK_STREAM: begin
					priority if (err_q) begin
						push = 1'b0;
					end else if (pay_left_q != 16'd0) begin
						pay_left_d       = pay_left_q - 16'd1;
						push             = 1'b1;
						res.kind         = OK_DATA;
						res.payload_byte = byte_s1;
						res.msg_type     = cur_type_q;
						res.msg_size     = cur_size_q;
						res.status       = HS_OK;
						res.last         = (pay_left_q == 16'd1);
					end else if (hdr_cnt_q != 2'(HDR_BYTES - 1)) begin
						hdr_cnt_d = hdr_cnt_q + 2'd1;
						unique case (hdr_cnt_q)
							2'd0:    hdr_shift_d[7:0]   = byte_s1;
							2'd1:    hdr_shift_d[15:8]  = byte_s1;
							default: hdr_shift_d[23:16] = byte_s1;
						endcase
					end else begin
						hdr_cnt_d    = 2'd0;
						hdr_shift_d  = '0;
						cur_type_d   = h_type;
						cur_size_d   = h_size;
						push         = 1'b1;
						res.msg_type = h_type;
						res.msg_size = h_size;
						res.kind     = OK_ERR;
						priority if (t_bad) begin
							res.status = HS_BAD_TYPE;
						end else if (h_size < entry.min_size || h_size > entry.max_size) begin
							res.status = HS_LIMITS;
						end else if (h_size < 16'(HDR_BYTES)) begin
							res.status = HS_SHORT;
						end else begin
							res.status = HS_OK;
						end
						if (res.status == HS_OK) begin
							res.kind   = OK_HDR;
							pay_left_d = h_size - 16'(HDR_BYTES);
							res.last   = (h_size == 16'(HDR_BYTES));
						end else begin
							err_d = 1'b1;
						end
					end
				end
				default: push = 1'b0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_cnt_q   <= '0;
			hdr_shift_q <= '0;
			pay_left_q  <= '0;
			cur_type_q  <= '0;
			cur_size_q  <= '0;
			err_q       <= 1'b0;
		end else begin
			hdr_cnt_q   <= hdr_cnt_d;
			hdr_shift_q <= hdr_shift_d;
			pay_left_q  <= pay_left_d;
			cur_type_q  <= cur_type_d;
			cur_size_q  <= cur_size_d;
			err_q       <= err_d;
		end
	end

	tlmd_out_fifo u_oq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (res),
		.count     (oq_cnt),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (oq_data)
	);

	assign out_kind        = oq_data.kind;
	assign payload_byte    = oq_data.payload_byte;
	assign msg_type        = oq_data.msg_type;
	assign msg_size        = oq_data.msg_size;
	assign status          = oq_data.status;
	assign last_of_message = oq_data.last;

endmodule
